@@ design/spc_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// spc_pkg
// shared types, codes and defaults of the sprite paste compositor
// ----------------------------------------------------------------------------
package spc_pkg;

    // default frame store geometry
    localparam int unsigned MAX_ROWS_DEF = 256;
    localparam int unsigned MAX_COLS_DEF = 256;

    // configuration port
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 9;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_ROWS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COLS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PASTE_ROW  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PASTE_COL  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BLEND_MODE = 3'd4;

    localparam logic [8:0] FRAME_ROWS_RST = 9'd256;
    localparam logic [8:0] FRAME_COLS_RST = 9'd256;

    // operation codes of an input beat
    typedef enum logic [1:0] {
        FUNC_STORE = 2'd0,
        FUNC_PASTE = 2'd1,
        FUNC_READ  = 2'd2
    } func_t;

    // result status codes
    typedef enum logic [1:0] {
        STAT_WRITTEN = 2'd0,
        STAT_OUTSIDE = 2'd1,
        STAT_SKIPPED = 2'd2,
        STAT_READ    = 2'd3
    } status_t;

    // one rgba pixel, red in the low byte
    typedef struct packed {
        logic [7:0] alpha;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } pixel_t;

    localparam pixel_t PIX_WHITE = '{alpha: 8'hFF, blue: 8'hFF, green: 8'hFF, red: 8'hFF};
    localparam pixel_t PIX_ZERO  = '{alpha: 8'h00, blue: 8'h00, green: 8'h00, red: 8'h00};

endpackage
`default_nettype wire

@@ design/spc_frame_mem.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// spc_frame_mem
// frame store: one write port, one registered read port, clearing pass
// to white after reset
// ----------------------------------------------------------------------------
module spc_frame_mem #(
    parameter int unsigned DEPTH = spc_pkg::MAX_ROWS_DEF * spc_pkg::MAX_COLS_DEF,
    parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  rd_en,
    input  wire  [AW-1:0]        rd_addr,
    output spc_pkg::pixel_t      rd_data,
    input  wire                  wr_en,
    input  wire  [AW-1:0]        wr_addr,
    input  wire spc_pkg::pixel_t wr_data,
    output logic                 clear_busy
);

    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

    spc_pkg::pixel_t mem_array [DEPTH];
    spc_pkg::pixel_t rd_data_reg;

    logic            clr_active_reg;
    logic            clr_active_next;
    logic [AW-1:0]   clr_cnt_reg;
    logic [AW-1:0]   clr_cnt_next;

    logic            mem_we;
    logic [AW-1:0]   mem_waddr;
    spc_pkg::pixel_t mem_wdata;

    // clearing sweep, one entry a cycle
    always_comb begin
        clr_active_next = clr_active_reg;
        clr_cnt_next    = clr_cnt_reg;
        if (clr_active_reg) begin
            if (clr_cnt_reg == LAST_ADDR) begin
                clr_active_next = 1'b0;
            end else begin
                clr_cnt_next = clr_cnt_reg + AW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_active_reg <= 1'b1;
            clr_cnt_reg    <= '0;
        end else begin
            clr_active_reg <= clr_active_next;
            clr_cnt_reg    <= clr_cnt_next;
        end
    end

    // sweep owns the write port while active
    always_comb begin
        if (clr_active_reg) begin
            mem_we    = 1'b1;
            mem_waddr = clr_cnt_reg;
            mem_wdata = spc_pkg::PIX_WHITE;
        end else begin
            mem_we    = wr_en;
            mem_waddr = wr_addr;
            mem_wdata = wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem_array[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem_array[rd_addr];
        end
    end

    assign rd_data    = rd_data_reg;
    assign clear_busy = clr_active_reg;

endmodule
`default_nettype wire

@@ design/sprite_paste_compositor_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sprite_paste_compositor_core
// rgba frame store with store, read-back and sprite paste (colour key on
// zero alpha, opaque replace or average blend) at a configured origin
// ----------------------------------------------------------------------------
// pipeline: a result goes through the stage 1 register and then the output
//   register, moving on once the output register is free
// throughput: one beat per cycle while the result side keeps up, outside the
//   clearing pass; the store read-modify-write over stages 0 and 1 is forwarded
// reset: synchronous, active low; afterwards a clearing pass over all
//   MAX_ROWS * MAX_COLS entries fills the store with white, s_ready stays low
//   meanwhile, configuration writes are taken throughout
module sprite_paste_compositor_core #(
    parameter int unsigned MAX_ROWS = spc_pkg::MAX_ROWS_DEF,
    parameter int unsigned MAX_COLS = spc_pkg::MAX_COLS_DEF
) (
    input  wire                              aclk,
    input  wire                              aresetn,

    // configuration write port
    input  wire                              cfg_wr_en,
    input  wire  [spc_pkg::CFG_IDX_W-1:0]    cfg_wr_index,
    input  wire  [spc_pkg::CFG_DATA_W-1:0]   cfg_wr_data,

    // input beats
    input  wire                              s_valid,
    output logic                             s_ready,
    input  wire  [1:0]                       s_func,
    input  wire  [7:0]                       s_row,
    input  wire  [7:0]                       s_col,
    input  wire  [7:0]                       s_pix_red,
    input  wire  [7:0]                       s_pix_green,
    input  wire  [7:0]                       s_pix_blue,
    input  wire  [7:0]                       s_pix_alpha,

    // result beats
    output logic                             m_valid,
    input  wire                              m_ready,
    output logic [7:0]                       m_out_red,
    output logic [7:0]                       m_out_green,
    output logic [7:0]                       m_out_blue,
    output logic [7:0]                       m_out_alpha,
    output logic [1:0]                       m_status
);

    localparam int unsigned DEPTH = MAX_ROWS * MAX_COLS;
    localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [8:0] frame_rows_reg;
    logic [8:0] frame_cols_reg;
    logic [8:0] paste_row_reg;
    logic [8:0] paste_col_reg;
    logic       blend_mode_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_rows_reg <= spc_pkg::FRAME_ROWS_RST;
            frame_cols_reg <= spc_pkg::FRAME_COLS_RST;
            paste_row_reg  <= '0;
            paste_col_reg  <= '0;
            blend_mode_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                spc_pkg::CFG_FRAME_ROWS: frame_rows_reg <= cfg_wr_data[8:0];
                spc_pkg::CFG_FRAME_COLS: frame_cols_reg <= cfg_wr_data[8:0];
                spc_pkg::CFG_PASTE_ROW:  paste_row_reg  <= cfg_wr_data[8:0];
                spc_pkg::CFG_PASTE_COL:  paste_col_reg  <= cfg_wr_data[8:0];
                spc_pkg::CFG_BLEND_MODE: blend_mode_reg <= cfg_wr_data[0];
                default: ;  // indexes beyond the register list are ignored
            endcase
        end
    end

    // ------------------------------------------------------------------
    // handshake and pipeline control
    // ------------------------------------------------------------------
    logic            clear_busy;
    logic            s_acc;
    logic            s1_go;

    logic            s1_valid_reg;
    logic [1:0]      s1_func_reg;
    logic            s1_inside_reg;
    logic [AW-1:0]   s1_addr_reg;
    spc_pkg::pixel_t s1_pix_reg;
    logic            s1_fwd_hit_reg;
    spc_pkg::pixel_t s1_fwd_pix_reg;

    logic            m_valid_reg;
    spc_pkg::pixel_t m_pix_reg;
    logic [1:0]      m_status_reg;

    // stage 1 moves on when the output register is free or being emptied
    assign s1_go   = s1_valid_reg && (!m_valid_reg || m_ready);
    // the input side stalls only behind a stalled stage 1 or the clearing pass
    assign s_ready = !clear_busy && (!s1_valid_reg || s1_go);
    assign s_acc   = s_valid && s_ready;

    // ------------------------------------------------------------------
    // stage 0: position, bounds check, address, memory read
    // ------------------------------------------------------------------
    logic [9:0]      row_sum;
    logic [9:0]      col_sum;
    logic [8:0]      row_idx;
    logic [8:0]      col_idx;
    logic            func_ok;
    logic            row_ok;
    logic            col_ok;
    logic            in_inside;
    logic [AW-1:0]   in_addr;
    spc_pkg::pixel_t in_pix;

    always_comb begin
        // a paste is shifted by the signed origin; store and read are not
        if (s_func == spc_pkg::FUNC_PASTE) begin
            row_sum = {2'b00, s_row} + {paste_row_reg[8], paste_row_reg};
            col_sum = {2'b00, s_col} + {paste_col_reg[8], paste_col_reg};
        end else begin
            row_sum = {2'b00, s_row};
            col_sum = {2'b00, s_col};
        end

        unique case (s_func)
            spc_pkg::FUNC_STORE,
            spc_pkg::FUNC_PASTE,
            spc_pkg::FUNC_READ: func_ok = 1'b1;
            default:            func_ok = 1'b0;  // unused code behaves as outside
        endcase

        // sums lie in -256..510: bit 9 flags a negative position
        row_idx = row_sum[8:0];
        col_idx = col_sum[8:0];
        row_ok  = !row_sum[9] && (row_idx < frame_rows_reg) &&
                  (32'(row_idx) < 32'(MAX_ROWS));
        col_ok  = !col_sum[9] && (col_idx < frame_cols_reg) &&
                  (32'(col_idx) < 32'(MAX_COLS));
        in_inside = func_ok && row_ok && col_ok;

        in_addr = AW'(32'(row_idx) * 32'(MAX_COLS) + 32'(col_idx));

        in_pix = '{alpha: s_pix_alpha, blue: s_pix_blue,
                   green: s_pix_green, red: s_pix_red};
    end

    // ------------------------------------------------------------------
    // frame store
    // ------------------------------------------------------------------
    spc_pkg::pixel_t rd_data;
    logic            s1_wr_need;
    spc_pkg::pixel_t s1_new_pix;

    spc_frame_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_frame_mem (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .rd_en      (s_acc),
        .rd_addr    (in_addr),
        .rd_data    (rd_data),
        .wr_en      (s1_go && s1_wr_need),
        .wr_addr    (s1_addr_reg),
        .wr_data    (s1_new_pix),
        .clear_busy (clear_busy)
    );

    // stage 1 registers; the forward flag catches a write to the same entry
    // in the very cycle this beat's read was issued (the read sees old data)
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_acc) begin
            s1_valid_reg <= 1'b1;
        end else if (s1_go) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            s1_func_reg    <= s_func;
            s1_inside_reg  <= in_inside;
            s1_addr_reg    <= in_addr;
            s1_pix_reg     <= in_pix;
            s1_fwd_hit_reg <= s1_go && s1_wr_need && (s1_addr_reg == in_addr);
            s1_fwd_pix_reg <= s1_new_pix;
        end
    end

    // ------------------------------------------------------------------
    // stage 1: modify and write back
    // ------------------------------------------------------------------
    spc_pkg::pixel_t cur_pix;
    spc_pkg::pixel_t avg_pix;
    spc_pkg::pixel_t s1_out_pix;
    logic [1:0]      s1_status;
    logic [8:0]      sum_red;
    logic [8:0]      sum_green;
    logic [8:0]      sum_blue;

    always_comb begin
        cur_pix = s1_fwd_hit_reg ? s1_fwd_pix_reg : rd_data;

        // truncated average per colour, frame alpha kept
        sum_red   = {1'b0, cur_pix.red}   + {1'b0, s1_pix_reg.red};
        sum_green = {1'b0, cur_pix.green} + {1'b0, s1_pix_reg.green};
        sum_blue  = {1'b0, cur_pix.blue}  + {1'b0, s1_pix_reg.blue};
        avg_pix   = '{alpha: cur_pix.alpha, blue: sum_blue[8:1],
                      green: sum_green[8:1], red: sum_red[8:1]};

        s1_wr_need = 1'b0;
        s1_new_pix = s1_pix_reg;
        s1_out_pix = spc_pkg::PIX_ZERO;
        s1_status  = spc_pkg::STAT_OUTSIDE;

        if (s1_inside_reg) begin
            unique case (s1_func_reg)
                spc_pkg::FUNC_STORE: begin
                    s1_wr_need = 1'b1;
                    s1_out_pix = s1_pix_reg;
                    s1_status  = spc_pkg::STAT_WRITTEN;
                end
                spc_pkg::FUNC_READ: begin
                    s1_out_pix = cur_pix;
                    s1_status  = spc_pkg::STAT_READ;
                end
                spc_pkg::FUNC_PASTE: begin
                    if (s1_pix_reg.alpha == 8'd0) begin
                        // colour key: fully transparent sprite pixel
                        s1_out_pix = cur_pix;
                        s1_status  = spc_pkg::STAT_SKIPPED;
                    end else begin
                        s1_wr_need = 1'b1;
                        s1_new_pix = blend_mode_reg ? avg_pix : s1_pix_reg;
                        s1_out_pix = s1_new_pix;
                        s1_status  = spc_pkg::STAT_WRITTEN;
                    end
                end
                default: ;  // never inside, handled by the defaults above
            endcase
        end
    end

    // ------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s1_go) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_go) begin
            m_pix_reg    <= s1_out_pix;
            m_status_reg <= s1_status;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_out_red   = m_pix_reg.red;
    assign m_out_green = m_pix_reg.green;
    assign m_out_blue  = m_pix_reg.blue;
    assign m_out_alpha = m_pix_reg.alpha;
    assign m_status    = m_status_reg;

endmodule
`default_nettype wire

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// sprite paste compositor core: directed and random store, read and paste
// beats with random idling on both sides, each result checked field by field
// against a behavioural frame store that keeps its own copy of the settings
// ----------------------------------------------------------------------------
module testbench;

    // frame store geometry of the instance, default parameters
    localparam int CANVAS_ROWS = int'(spc_pkg::MAX_ROWS_DEF);
    localparam int CANVAS_COLS = int'(spc_pkg::MAX_COLS_DEF);
    // spare operation code, not part of func_t
    localparam logic [1:0] FUNC_SPARE = 2'd3;
    // clearing pass plus every beat waiting out both worst idle bursts, several times over
    localparam int CYCLE_LIMIT = 600000;
    // only the first few mismatches are printed, all are counted
    localparam int MAX_NOTES = 30;
    // side of the hot window that packs accesses onto a few pixels
    localparam int HOT_SPAN = 8;

    // what one result beat should carry
    typedef struct packed {
        spc_pkg::status_t status;
        spc_pkg::pixel_t  pix;
    } outcome_t;

    // ------------------------------------------------------------------------
    // block signals, all inputs known from time zero
    // ------------------------------------------------------------------------
    logic                           aclk         = 1'b0;
    logic                           aresetn      = 1'b0;
    logic                           cfg_wr_en    = 1'b0;
    logic [spc_pkg::CFG_IDX_W-1:0]  cfg_wr_index = spc_pkg::CFG_FRAME_ROWS;
    logic [spc_pkg::CFG_DATA_W-1:0] cfg_wr_data  = '0;
    logic                           s_valid      = 1'b0;
    logic                           s_ready;
    logic [1:0]                     s_func       = spc_pkg::FUNC_STORE;
    logic [7:0]                     s_row        = '0;
    logic [7:0]                     s_col        = '0;
    logic [7:0]                     s_pix_red    = '0;
    logic [7:0]                     s_pix_green  = '0;
    logic [7:0]                     s_pix_blue   = '0;
    logic [7:0]                     s_pix_alpha  = '0;
    logic                           m_valid;
    logic                           m_ready      = 1'b0;
    logic [7:0]                     m_out_red;
    logic [7:0]                     m_out_green;
    logic [7:0]                     m_out_blue;
    logic [7:0]                     m_out_alpha;
    logic [1:0]                     m_status;

    // ------------------------------------------------------------------------
    // behavioural copy of the frame store and of the registers
    // ------------------------------------------------------------------------
    spc_pkg::pixel_t canvas [0:CANVAS_ROWS*CANVAS_COLS-1];
    logic [8:0] canvas_rows      = spc_pkg::FRAME_ROWS_RST;
    logic [8:0] canvas_cols      = spc_pkg::FRAME_COLS_RST;
    logic [8:0] canvas_paste_row = '0;
    logic [8:0] canvas_paste_col = '0;
    logic       canvas_blend     = 1'b0;

    outcome_t   pending_pixels [$];

    // run bookkeeping
    int  cycle_count     = 0;
    int  fail_count      = 0;
    int  beats_sent      = 0;
    int  results_checked = 0;
    int  settings_used   = 0;
    bit  source_gaps     = 1'b0;
    bit  sink_stalls     = 1'b0;
    int  sink_hold       = 0;

    sprite_paste_compositor_core dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_func       (s_func),
        .s_row        (s_row),
        .s_col        (s_col),
        .s_pix_red    (s_pix_red),
        .s_pix_green  (s_pix_green),
        .s_pix_blue   (s_pix_blue),
        .s_pix_alpha  (s_pix_alpha),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_red    (m_out_red),
        .m_out_green  (m_out_green),
        .m_out_blue   (m_out_blue),
        .m_out_alpha  (m_out_alpha),
        .m_status     (m_status)
    );

    // 10 ns clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // watchdog, ends a hung run
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("no progress, run stopped after %0d cycles", cycle_count);
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------------

    // truncated mean of two channel values, carry kept
    function automatic logic [7:0] mean8(input logic [7:0] a, input logic [7:0] b);
        logic [8:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[8:1];
    endfunction

    // works out one result beat and updates the frame store copy
    function automatic outcome_t composite(input logic [1:0] op, input logic [7:0] row,
                                           input logic [7:0] col,
                                           input spc_pkg::pixel_t pix);
        outcome_t        res;
        spc_pkg::pixel_t cur;
        int              r;
        int              c;
        int              rows_in;
        int              cols_in;
        int              at;
        res.status = spc_pkg::STAT_OUTSIDE;
        res.pix    = spc_pkg::PIX_ZERO;
        r = int'(row);
        c = int'(col);
        if (op == FUNC_SPARE)
            return res;
        // paste lands relative to the signed origin
        if (op == spc_pkg::FUNC_PASTE) begin
            r = r + int'($signed(canvas_paste_row));
            c = c + int'($signed(canvas_paste_col));
        end
        rows_in = (int'(canvas_rows) < CANVAS_ROWS) ? int'(canvas_rows) : CANVAS_ROWS;
        cols_in = (int'(canvas_cols) < CANVAS_COLS) ? int'(canvas_cols) : CANVAS_COLS;
        if (r < 0 || r >= rows_in || c < 0 || c >= cols_in)
            return res;
        at  = r * CANVAS_COLS + c;
        cur = canvas[at];
        if (op == spc_pkg::FUNC_STORE) begin
            // stored as given, alpha included
            canvas[at] = pix;
            res.pix    = pix;
            res.status = spc_pkg::STAT_WRITTEN;
        end else if (op == spc_pkg::FUNC_READ) begin
            res.pix    = cur;
            res.status = spc_pkg::STAT_READ;
        end else if (pix.alpha == 8'h00) begin
            // colour key: transparent sprite pixel leaves the frame alone
            res.pix    = cur;
            res.status = spc_pkg::STAT_SKIPPED;
        end else begin
            if (canvas_blend) begin
                res.pix.red   = mean8(cur.red, pix.red);
                res.pix.green = mean8(cur.green, pix.green);
                res.pix.blue  = mean8(cur.blue, pix.blue);
                res.pix.alpha = cur.alpha;
            end else begin
                res.pix = pix;
            end
            canvas[at] = res.pix;
            res.status = spc_pkg::STAT_WRITTEN;
        end
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------------
    task automatic note_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        fail_count++;
        if (fail_count <= MAX_NOTES)
            $display("mismatch at cycle %0d: %s got %0h, expected %0h",
                     cycle_count, what, got, want);
    endtask

    // sampled at the falling edge: everything is settled and the next rising
    // edge takes exactly what is seen here
    always @(negedge aclk) begin
        outcome_t want;
        if (aresetn) begin
            // register writes go straight into the copy of the settings
            if (cfg_wr_en) begin
                case (cfg_wr_index)
                    spc_pkg::CFG_FRAME_ROWS: canvas_rows      = cfg_wr_data;
                    spc_pkg::CFG_FRAME_COLS: canvas_cols      = cfg_wr_data;
                    spc_pkg::CFG_PASTE_ROW:  canvas_paste_row = cfg_wr_data;
                    spc_pkg::CFG_PASTE_COL:  canvas_paste_col = cfg_wr_data;
                    spc_pkg::CFG_BLEND_MODE: canvas_blend     = cfg_wr_data[0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready)
                pending_pixels.push_back(composite(s_func, s_row, s_col,
                    {s_pix_alpha, s_pix_blue, s_pix_green, s_pix_red}));
            if (m_valid && m_ready) begin
                if (pending_pixels.size() == 0) begin
                    note_mismatch("result beat with nothing pending, status",
                                  32'(m_status), 32'd0);
                end else begin
                    want = pending_pixels.pop_front();
                    results_checked++;
                    if (m_out_red !== want.pix.red)
                        note_mismatch("red", 32'(m_out_red), 32'(want.pix.red));
                    if (m_out_green !== want.pix.green)
                        note_mismatch("green", 32'(m_out_green), 32'(want.pix.green));
                    if (m_out_blue !== want.pix.blue)
                        note_mismatch("blue", 32'(m_out_blue), 32'(want.pix.blue));
                    if (m_out_alpha !== want.pix.alpha)
                        note_mismatch("alpha", 32'(m_out_alpha), 32'(want.pix.alpha));
                    if (m_status !== want.status)
                        note_mismatch("status", 32'(m_status), 32'(want.status));
                end
            end
        end
    end

    // result side: random stall bursts of random length while enabled
    always @(posedge aclk) begin
        if (sink_hold > 0) begin
            sink_hold--;
        end else if (sink_stalls && $urandom_range(0, 9) == 0) begin
            m_ready   <= 1'b0;
            sink_hold = $urandom_range(0, 16);
        end else begin
            m_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // stimulus helpers, all entered just after a rising edge
    // ------------------------------------------------------------------------

    // one input beat; valid stays up for a following beat unless a gap comes
    task automatic send_beat(input logic [1:0] op, input logic [7:0] row,
                             input logic [7:0] col, input spc_pkg::pixel_t pix);
        bit taken;
        if (source_gaps && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_func      <= op;
        s_row       <= row;
        s_col       <= col;
        s_pix_red   <= pix.red;
        s_pix_green <= pix.green;
        s_pix_blue  <= pix.blue;
        s_pix_alpha <= pix.alpha;
        do begin
            @(negedge aclk);
            taken = s_ready;
            @(posedge aclk);
        end while (!taken);
        beats_sent++;
    endtask

    // stop sending and wait for every pending result
    task automatic settle();
        s_valid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge aclk);
    endtask

    task automatic write_reg(input logic [spc_pkg::CFG_IDX_W-1:0] index,
                             input logic [8:0] value);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= index;
        cfg_wr_data  <= value;
        @(posedge aclk);
    endtask

    // all five registers, only once the block has gone idle
    task automatic program_canvas(input int rows, input int cols, input int org_row,
                                  input int org_col, input bit blend);
        settle();
        write_reg(spc_pkg::CFG_FRAME_ROWS, rows[8:0]);
        write_reg(spc_pkg::CFG_FRAME_COLS, cols[8:0]);
        write_reg(spc_pkg::CFG_PASTE_ROW, org_row[8:0]);
        write_reg(spc_pkg::CFG_PASTE_COL, org_col[8:0]);
        write_reg(spc_pkg::CFG_BLEND_MODE, {8'd0, blend});
        cfg_wr_en <= 1'b0;
        settings_used++;
    endtask

    // coordinate mostly inside a small window near the frame origin, after
    // undoing the paste offset, so that beats keep hitting the same pixels
    function automatic logic [7:0] pick_coord(input int shift, input int extent);
        int t;
        case ($urandom_range(0, 11))
            0: return 8'(int'($urandom_range(0, 255)));
            1: return 8'd0;
            2: return 8'd255;
            3: t = extent - 1 - shift;      // last row or column in use
            4: t = extent - shift;          // one past the edge
            default: t = int'($urandom_range(0, ((extent < HOT_SPAN) ? extent : HOT_SPAN) - 1))
                         - shift;
        endcase
        if (t < 0 || t > 255)
            return 8'(int'($urandom_range(0, 255)));
        return t[7:0];
    endfunction

    // random beats under whatever settings are programmed
    task automatic run_traffic(input int count);
        int              rows_in;
        int              cols_in;
        int              shift_r;
        int              shift_c;
        int              pick;
        logic [1:0]      op;
        spc_pkg::pixel_t pix;
        rows_in = (int'(canvas_rows) < CANVAS_ROWS) ? int'(canvas_rows) : CANVAS_ROWS;
        cols_in = (int'(canvas_cols) < CANVAS_COLS) ? int'(canvas_cols) : CANVAS_COLS;
        repeat (count) begin
            pick = $urandom_range(0, 19);
            if (pick < 6)
                op = spc_pkg::FUNC_STORE;
            else if (pick < 13)
                op = spc_pkg::FUNC_PASTE;
            else if (pick < 19)
                op = spc_pkg::FUNC_READ;
            else
                op = FUNC_SPARE;
            shift_r = 0;
            shift_c = 0;
            if (op == spc_pkg::FUNC_PASTE) begin
                shift_r = int'($signed(canvas_paste_row));
                shift_c = int'($signed(canvas_paste_col));
            end
            pix = $urandom();
            case ($urandom_range(0, 9))
                0: pix.alpha = 8'h00;
                1: pix = spc_pkg::PIX_ZERO;
                2: pix = spc_pkg::PIX_WHITE;
                3: pix.alpha = 8'hFF;
                default: ;
            endcase
            send_beat(op, pick_coord(shift_r, rows_in), pick_coord(shift_c, cols_in), pix);
        end
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // store comes out of the clearing pass white; spare code reads as outside
    task automatic test_power_up_contents();
        send_beat(spc_pkg::FUNC_READ, 8'd0, 8'd0, spc_pkg::PIX_ZERO);
        send_beat(spc_pkg::FUNC_READ, 8'd255, 8'd255, spc_pkg::PIX_ZERO);
        send_beat(FUNC_SPARE, 8'd7, 8'd9, spc_pkg::PIX_WHITE);
    endtask

    // corner stores, zero alpha stored as is, the first two read back straight after
    task automatic test_store_and_read();
        send_beat(spc_pkg::FUNC_STORE, 8'd0, 8'd0, 32'h00000000);
        send_beat(spc_pkg::FUNC_READ, 8'd0, 8'd0, spc_pkg::PIX_WHITE);
        send_beat(spc_pkg::FUNC_STORE, 8'd255, 8'd0, 32'h00563412);
        send_beat(spc_pkg::FUNC_READ, 8'd255, 8'd0, spc_pkg::PIX_ZERO);
        send_beat(spc_pkg::FUNC_STORE, 8'd255, 8'd255, 32'h80402010);
    endtask

    // opaque replace then a transparent pixel on the same spot, back to back
    task automatic test_paste_opaque_and_skip();
        send_beat(spc_pkg::FUNC_PASTE, 8'd1, 8'd1, 32'h7FABCDEF);
        send_beat(spc_pkg::FUNC_PASTE, 8'd1, 8'd1, 32'h00112233);
        send_beat(spc_pkg::FUNC_READ, 8'd1, 8'd1, spc_pkg::PIX_ZERO);
    endtask

    // origin at both extremes, landing just off and just on the frame
    task automatic test_origin_bounds();
        program_canvas(256, 256, -256, -256, 1'b0);
        send_beat(spc_pkg::FUNC_PASTE, 8'd255, 8'd255, spc_pkg::PIX_WHITE);
        program_canvas(256, 256, 255, 255, 1'b1);
        send_beat(spc_pkg::FUNC_PASTE, 8'd0, 8'd0, 32'h01FF00FF);
        send_beat(spc_pkg::FUNC_PASTE, 8'd0, 8'd1, 32'hFFFFFFFF);
        send_beat(spc_pkg::FUNC_READ, 8'd255, 8'd255, spc_pkg::PIX_ZERO);
    endtask

    // single pixel frame: averages chained through the read-modify-write path
    task automatic test_tiny_frame_blend();
        program_canvas(1, 1, 0, 0, 1'b1);
        send_beat(spc_pkg::FUNC_STORE, 8'd0, 8'd0, 32'h01FF00FE);
        send_beat(spc_pkg::FUNC_PASTE, 8'd0, 8'd0, 32'hFFFF01FF);
        send_beat(spc_pkg::FUNC_PASTE, 8'd0, 8'd0, 32'h1000FF01);
        send_beat(spc_pkg::FUNC_READ, 8'd0, 8'd0, spc_pkg::PIX_ZERO);
        send_beat(spc_pkg::FUNC_READ, 8'd0, 8'd1, spc_pkg::PIX_ZERO);
        send_beat(spc_pkg::FUNC_STORE, 8'd1, 8'd0, spc_pkg::PIX_WHITE);
        send_beat(spc_pkg::FUNC_PASTE, 8'd0, 8'd0, 32'h00FFFFFF);
    endtask

    // random traffic over a spread of settings, idling off at the end
    task automatic test_random_traffic();
        source_gaps = 1'b1;
        sink_stalls = 1'b1;
        program_canvas(256, 256, 0, 0, 1'b0);
        run_traffic(300);
        program_canvas(256, 256, -3, 5, 1'b1);
        run_traffic(250);
        program_canvas(1, 1, 0, 0, 1'b1);
        run_traffic(120);
        repeat (2) begin
            program_canvas($urandom_range(1, 256), $urandom_range(1, 256),
                           int'($urandom_range(0, 511)) - 256,
                           int'($urandom_range(0, 511)) - 256,
                           1'($urandom_range(0, 1)));
            run_traffic(200);
        end
        program_canvas(256, 1, -256, 255, 1'b0);
        run_traffic(150);
        // last stretch flat out on both sides
        program_canvas(200, 17, 1, -1, 1'b1);
        source_gaps = 1'b0;
        sink_stalls = 1'b0;
        run_traffic(250);
    endtask

    // ------------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------------
    initial begin
        for (int i = 0; i < CANVAS_ROWS * CANVAS_COLS; i++)
            canvas[i] = spc_pkg::PIX_WHITE;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // directed part runs back to back, no idling
        test_power_up_contents();
        test_store_and_read();
        test_paste_opaque_and_skip();
        test_origin_bounds();
        test_tiny_frame_blend();
        test_random_traffic();

        // drain, then allow for the pipeline to show any stray beat
        settle();
        repeat (8) @(posedge aclk);
        $display("%0d input beats and %0d result beats under %0d register settings",
                 beats_sent, results_checked, settings_used);
        $display("store, read, opaque and blended paste, colour key, frame and origin limits");
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("%0d mismatches in total", fail_count);
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

@@ sprite_paste_compositor_core.f @@
design/spc_pkg.sv
design/spc_frame_mem.sv
design/sprite_paste_compositor_core.sv
tb/testbench.sv
